[rtl/ps2mpt_pkg.sv]
// ============================================================================
// ps2mpt_pkg
// Shared types and constants for the PS/2 mouse packet tracker.
// ============================================================================
`default_nettype none

package ps2mpt_pkg;

   // Cursor position width and derived arithmetic widths
   localparam int POS_W   = 12;
   localparam int CFG_W   = 13;                          // widest register
   localparam int DELTA_W = 12;                          // 9-bit delta times 3-bit factor
   localparam int SUM_W   = ((POS_W > DELTA_W) ? POS_W : DELTA_W) + 2;
   localparam int LIM_W   = (POS_W > CFG_W) ? POS_W : CFG_W;
   localparam int CNT_W   = 32;

   localparam logic [POS_W-1:0] MAX_POS = {POS_W{1'b1}};

   // Register reset values
   localparam logic [CFG_W-1:0] SCREEN_WIDTH_RESET    = CFG_W'(640);
   localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RESET   = CFG_W'(480);
   localparam logic [7:0]       ACCEL_THRESHOLD_RESET = 8'd5;
   localparam logic [2:0]       ACCEL_FACTOR_RESET    = 3'd2;

   // State reset values
   localparam logic [POS_W-1:0] CURSOR_X_RESET = POS_W'(160);
   localparam logic [POS_W-1:0] CURSOR_Y_RESET = POS_W'(100);

   // Controller status bits
   localparam int STATUS_OUT_FULL = 0;
   localparam int STATUS_AUX_DATA = 5;

   // Header byte bits
   localparam int HDR_ALWAYS_ONE = 3;
   localparam int HDR_X_SIGN     = 4;
   localparam int HDR_Y_SIGN     = 5;
   localparam int HDR_X_OVFL     = 6;
   localparam int HDR_Y_OVFL     = 7;

   // Register indexes
   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCREEN_WIDTH    = 2'd0,
      CSR_SCREEN_HEIGHT   = 2'd1,
      CSR_ACCEL_THRESHOLD = 2'd2,
      CSR_ACCEL_FACTOR    = 2'd3
   } csr_index_type;

   // Packet byte phase, one-hot
   typedef enum logic [2:0] {
      PH_HEADER = 3'b001,
      PH_X_BYTE = 3'b010,
      PH_Y_BYTE = 3'b100
   } phase_type;

endpackage

`default_nettype wire

[rtl/ps2mpt_axis.sv]
// ============================================================================
// ps2mpt_axis
// One axis of cursor motion: acceleration, position update and clamp.
// ============================================================================
`default_nettype none

module ps2mpt_axis
   import ps2mpt_pkg::*;
(
   input  wire logic [POS_W-1:0] cur_pos,
   input  wire logic [7:0]       delta_low,
   input  wire logic             delta_sign,
   input  wire logic             subtract,
   input  wire logic [7:0]       threshold,
   input  wire logic [2:0]       factor,
   input  wire logic [CFG_W-1:0] screen_size,
   output logic      [POS_W-1:0] new_pos
);

   logic signed [8:0]       delta;
   logic        [8:0]       magnitude;
   logic signed [SUM_W-1:0] delta_ext;
   logic signed [SUM_W-1:0] scaled;
   logic signed [SUM_W-1:0] accel_delta;
   logic signed [SUM_W-1:0] pos_ext;
   logic signed [SUM_W-1:0] sum;
   logic        [CFG_W-1:0] size_m1;
   logic        [LIM_W-1:0] size_ext;
   logic        [LIM_W-1:0] max_ext;
   logic        [LIM_W-1:0] limit;
   logic signed [SUM_W-1:0] limit_ext;

   // 9-bit two's complement delta and its magnitude
   assign delta     = $signed({delta_sign, delta_low});
   assign magnitude = delta_sign ? (~{delta_sign, delta_low} + 9'd1)
                                 : {delta_sign, delta_low};

   // Acceleration beyond threshold
   assign delta_ext   = SUM_W'(delta);
   assign scaled      = delta_ext * SUM_W'($signed({1'b0, factor}));
   assign accel_delta = (magnitude > {1'b0, threshold}) ? scaled : delta_ext;

   // New unclamped position
   assign pos_ext = SUM_W'($signed({1'b0, cur_pos}));
   assign sum     = subtract ? (pos_ext - accel_delta) : (pos_ext + accel_delta);

   // Screen limit: size of zero acts as one, saturate at position range
   assign size_m1   = (screen_size == '0) ? '0 : (screen_size - CFG_W'(1));
   assign size_ext  = LIM_W'(size_m1);
   assign max_ext   = LIM_W'(MAX_POS);
   assign limit     = (size_ext > max_ext) ? max_ext : size_ext;
   assign limit_ext = $signed(SUM_W'(limit));

   // Clamp
   always_comb begin
      if (sum < 0) begin
         new_pos = '0;
      end else if (sum > limit_ext) begin
         new_pos = POS_W'(limit);
      end else begin
         new_pos = POS_W'(sum);
      end
   end

endmodule

`default_nettype wire

[rtl/ps2_mouse_packet_tracker_top.sv]
// ============================================================================
// ps2_mouse_packet_tracker_top
// Assembles three-byte PS/2 mouse packets and tracks the cursor position.
// ============================================================================
// Usage:
//  - Request channel (req_*): one controller status byte and data byte per
//    request. Bytes without output-full and aux-data status change nothing
//    but still return a response.
//  - Response channel (rsp_*): exactly one response per request, carrying
//    cursor position, buttons, per-byte flags and the two wrapping counters.
//  - Registered response: a request accepted at one edge shows its response
//    from the next. Throughput is one request per cycle while responses are
//    taken, set by the single combinational update between state and flag regs.
//  - The tracker state doubles as the response payload register; it only
//    changes when a request is accepted, which is only when the response slot
//    is empty or being taken in the same cycle.
//  - If the receiver stalls, req_ready drops while a response waits, and the
//    response holds unchanged until taken.
//  - Reset (synchronous) restores all registers to their defaults: 640x480
//    screen, threshold 5, factor 2, cursor at (160,100), counters cleared.
//  - csr_* writes take effect at the edge of csr_we; write only while idle.
// ============================================================================
`default_nettype none

module ps2_mouse_packet_tracker_top
   import ps2mpt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata,

   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [7:0]           req_ctrl_status,
   input  wire logic [7:0]           req_rx_byte,

   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic      [POS_W-1:0]     rsp_pos_x,
   output logic      [POS_W-1:0]     rsp_pos_y,
   output logic      [2:0]           rsp_button_bits,
   output logic                      rsp_packet_done,
   output logic                      rsp_motion_dropped,
   output logic                      rsp_sync_error,
   output logic      [CNT_W-1:0]     rsp_packets_seen,
   output logic      [CNT_W-1:0]     rsp_errors_seen
);

   // Configuration registers
   logic [CFG_W-1:0] screen_width_ff;
   logic [CFG_W-1:0] screen_height_ff;
   logic [7:0]       accel_threshold_ff;
   logic [2:0]       accel_factor_ff;

   // Tracker state
   phase_type        phase_ff,   phase_in;
   logic [7:0]       header_ff,  header_in;
   logic [7:0]       x_byte_ff,  x_byte_in;
   logic [POS_W-1:0] cursor_x_ff, cursor_x_in;
   logic [POS_W-1:0] cursor_y_ff, cursor_y_in;
   logic [2:0]       buttons_ff, buttons_in;
   logic [CNT_W-1:0] pkt_cnt_ff, pkt_cnt_in;
   logic [CNT_W-1:0] err_cnt_ff, err_cnt_in;

   // Response slot
   logic             rsp_valid_ff, rsp_valid_in;
   logic             done_ff,    done_in;
   logic             dropped_ff, dropped_in;
   logic             serr_ff,    serr_in;

   logic             accept;
   logic             byte_taken;
   logic             overflow;
   logic [POS_W-1:0] moved_x;
   logic [POS_W-1:0] moved_y;

   // Handshake
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;
   assign byte_taken = req_ctrl_status[STATUS_OUT_FULL] && req_ctrl_status[STATUS_AUX_DATA];
   assign overflow   = header_ff[HDR_X_OVFL] || header_ff[HDR_Y_OVFL];

   // Per-axis motion
   ps2mpt_axis u_axis_x (
      .cur_pos     (cursor_x_ff),
      .delta_low   (x_byte_ff),
      .delta_sign  (header_ff[HDR_X_SIGN]),
      .subtract    (1'b0),
      .threshold   (accel_threshold_ff),
      .factor      (accel_factor_ff),
      .screen_size (screen_width_ff),
      .new_pos     (moved_x)
   );

   ps2mpt_axis u_axis_y (
      .cur_pos     (cursor_y_ff),
      .delta_low   (req_rx_byte),
      .delta_sign  (header_ff[HDR_Y_SIGN]),
      .subtract    (1'b1),
      .threshold   (accel_threshold_ff),
      .factor      (accel_factor_ff),
      .screen_size (screen_height_ff),
      .new_pos     (moved_y)
   );

   // Packet assembly and state update
   always_comb begin
      phase_in     = phase_ff;
      header_in    = header_ff;
      x_byte_in    = x_byte_ff;
      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;
      buttons_in   = buttons_ff;
      pkt_cnt_in   = pkt_cnt_ff;
      err_cnt_in   = err_cnt_ff;
      done_in      = done_ff;
      dropped_in   = dropped_ff;
      serr_in      = serr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (accept) begin
         rsp_valid_in = 1'b1;
         done_in      = 1'b0;
         dropped_in   = 1'b0;
         serr_in      = 1'b0;
         if (byte_taken) begin
            unique case (phase_ff)
               PH_X_BYTE: begin
                  x_byte_in = req_rx_byte;
                  phase_in  = PH_Y_BYTE;
               end
               PH_Y_BYTE: begin
                  phase_in   = PH_HEADER;
                  done_in    = 1'b1;
                  pkt_cnt_in = pkt_cnt_ff + CNT_W'(1);
                  buttons_in = header_ff[2:0];
                  if (overflow) begin
                     dropped_in = 1'b1;
                  end else begin
                     cursor_x_in = moved_x;
                     cursor_y_in = moved_y;
                  end
               end
               default: begin
                  // header byte
                  if (!req_rx_byte[HDR_ALWAYS_ONE]) begin
                     phase_in   = PH_HEADER;
                     serr_in    = 1'b1;
                     err_cnt_in = err_cnt_ff + CNT_W'(1);
                  end else begin
                     header_in = req_rx_byte;
                     phase_in  = PH_X_BYTE;
                  end
               end
            endcase
         end
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff    <= SCREEN_WIDTH_RESET;
         screen_height_ff   <= SCREEN_HEIGHT_RESET;
         accel_threshold_ff <= ACCEL_THRESHOLD_RESET;
         accel_factor_ff    <= ACCEL_FACTOR_RESET;
         phase_ff           <= PH_HEADER;
         header_ff          <= '0;
         x_byte_ff          <= '0;
         cursor_x_ff        <= CURSOR_X_RESET;
         cursor_y_ff        <= CURSOR_Y_RESET;
         buttons_ff         <= '0;
         pkt_cnt_ff         <= '0;
         err_cnt_ff         <= '0;
         rsp_valid_ff       <= 1'b0;
         done_ff            <= 1'b0;
         dropped_ff         <= 1'b0;
         serr_ff            <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         header_ff    <= header_in;
         x_byte_ff    <= x_byte_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         buttons_ff   <= buttons_in;
         pkt_cnt_ff   <= pkt_cnt_in;
         err_cnt_ff   <= err_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
         dropped_ff   <= dropped_in;
         serr_ff      <= serr_in;
         // configuration write decode
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_SCREEN_WIDTH:    screen_width_ff    <= csr_wdata;
               CSR_SCREEN_HEIGHT:   screen_height_ff   <= csr_wdata;
               CSR_ACCEL_THRESHOLD: accel_threshold_ff <= csr_wdata[7:0];
               CSR_ACCEL_FACTOR:    accel_factor_ff    <= csr_wdata[2:0];
               default: ;
            endcase
         end
      end
   end

   // Response outputs
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pos_x          = cursor_x_ff;
   assign rsp_pos_y          = cursor_y_ff;
   assign rsp_button_bits    = buttons_ff;
   assign rsp_packet_done    = done_ff;
   assign rsp_motion_dropped = dropped_ff;
   assign rsp_sync_error     = serr_ff;
   assign rsp_packets_seen   = pkt_cnt_ff;
   assign rsp_errors_seen    = err_cnt_ff;

endmodule

`default_nettype wire

[rtl/ps2mpt_checker.sv]
// ============================================================================
// ps2mpt_checker
// Port-level checks for the PS/2 mouse packet tracker, bound to the top.
// ============================================================================
`default_nettype none

module ps2mpt_checker
   import ps2mpt_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic             rsp_packet_done,
   input wire logic             rsp_motion_dropped,
   input wire logic             rsp_sync_error,
   input wire logic [CNT_W-1:0] rsp_packets_seen,
   input wire logic [CNT_W-1:0] rsp_errors_seen
);

   logic             seen_ff;
   logic [CNT_W-1:0] last_pkt_ff;
   logic [CNT_W-1:0] last_err_ff;
   logic             rsp_fire;

   assign rsp_fire = rsp_valid && rsp_ready;

   // Counters as of the last delivered response
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_fire) begin
         seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         last_pkt_ff <= rsp_packets_seen;
         last_err_ff <= rsp_errors_seen;
      end
   end

   // A stalled response stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
   else $error("response withdrawn while stalled");

   // A byte cannot both finish a packet and be a dropped header
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_packet_done && rsp_sync_error))
   else $error("packet done and sync error together");

   // Dropped motion only on a finished packet
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_motion_dropped |-> rsp_packet_done)
   else $error("motion dropped without a finished packet");

   // Packet count steps by exactly the packet flag from response to response
   assert property (@(posedge clock) disable iff (reset)
      rsp_fire && seen_ff |->
         rsp_packets_seen == last_pkt_ff + CNT_W'(rsp_packet_done))
   else $error("packet count out of step");

   // Error count steps by exactly the sync error flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_fire && seen_ff |->
         rsp_errors_seen == last_err_ff + CNT_W'(rsp_sync_error))
   else $error("error count out of step");

endmodule

bind ps2_mouse_packet_tracker_top ps2mpt_checker u_ps2mpt_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_packet_done    (rsp_packet_done),
   .rsp_motion_dropped (rsp_motion_dropped),
   .rsp_sync_error     (rsp_sync_error),
   .rsp_packets_seen   (rsp_packets_seen),
   .rsp_errors_seen    (rsp_errors_seen)
);

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker testbench
// Feeds controller status/data byte pairs through the request channel, keeps
// its own cursor tracker in step with every accepted request and checks each
// response field by field. A short table of directed requests is followed by
// randomised packet streams under a series of screen and acceleration
// settings, with gaps on the request side and stalls on the response side.
// ----------------------------------------------------------------------------

module testbench;
   import ps2mpt_pkg::*;

   // One response as seen on the rsp_* ports
   typedef struct packed {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [2:0]       button_bits;
      logic             packet_done;
      logic             motion_dropped;
      logic             sync_error;
      logic [CNT_W-1:0] packets_seen;
      logic [CNT_W-1:0] errors_seen;
   } cursor_report_type;

   typedef struct packed {
      logic [7:0]        status;
      logic [7:0]        data;
      logic              typed;
      cursor_report_type want;
   } directed_row_type;

   typedef struct packed {
      logic [CFG_W-1:0] width;
      logic [CFG_W-1:0] height;
      logic [7:0]       threshold;
      logic [2:0]       factor;
   } screen_setting_type;

   localparam cursor_report_type AT_RESET = '{CURSOR_X_RESET, CURSOR_Y_RESET, 3'd0,
                                              1'b0, 1'b0, 1'b0, 32'd0, 32'd0};
   localparam cursor_report_type FIRST_SYNC_ERR = '{CURSOR_X_RESET, CURSOR_Y_RESET, 3'd0,
                                                    1'b0, 1'b0, 1'b1, 32'd0, 32'd1};
   localparam cursor_report_type SECOND_SYNC_ERR = '{CURSOR_X_RESET, CURSOR_Y_RESET, 3'd0,
                                                     1'b0, 1'b0, 1'b1, 32'd0, 32'd2};
   localparam cursor_report_type HEADER_AFTER_ERR = '{CURSOR_X_RESET, CURSOR_Y_RESET, 3'd0,
                                                      1'b0, 1'b0, 1'b0, 32'd0, 32'd2};

   // Directed requests, run with the reset settings
   localparam int DIRECTED_ROWS = 26;
   localparam directed_row_type DIRECTED [0:DIRECTED_ROWS-1] = '{
      '{8'h00, 8'hFF, 1'b1, AT_RESET},          // no status bits: ignored
      '{8'h01, 8'h08, 1'b1, AT_RESET},          // output full only
      '{8'h20, 8'h08, 1'b1, AT_RESET},          // aux only
      '{8'h21, 8'h00, 1'b1, FIRST_SYNC_ERR},    // header without bit 3
      '{8'hFF, 8'hF7, 1'b1, SECOND_SYNC_ERR},
      '{8'h21, 8'h08, 1'b1, HEADER_AFTER_ERR},  // plain header
      '{8'h21, 8'h05, 1'b0, '0},                // dx at threshold, not scaled
      '{8'h21, 8'h03, 1'b0, '0},
      '{8'h21, 8'h0F, 1'b0, '0},                // all buttons, large +dx
      '{8'hE1, 8'hFF, 1'b0, '0},
      '{8'h21, 8'h00, 1'b0, '0},
      '{8'h21, 8'h38, 1'b0, '0},                // both signs, -256 each way
      '{8'h21, 8'h00, 1'b0, '0},
      '{8'h21, 8'h00, 1'b0, '0},
      '{8'h21, 8'h48, 1'b0, '0},                // x overflow: motion dropped
      '{8'h21, 8'h12, 1'b0, '0},
      '{8'h21, 8'h34, 1'b0, '0},
      '{8'hDE, 8'h08, 1'b0, '0},                // ignored between packets
      '{8'hFF, 8'hBF, 1'b0, '0},                // y overflow with buttons
      '{8'h21, 8'hAA, 1'b0, '0},
      '{8'h01, 8'h55, 1'b0, '0},                // ignored mid-packet
      '{8'h21, 8'h55, 1'b0, '0},
      '{8'h21, 8'h18, 1'b0, '0},                // dx -1, dy +255
      '{8'h21, 8'hFF, 1'b0, '0},
      '{8'h21, 8'hFF, 1'b0, '0},
      '{8'h21, 8'hF0, 1'b0, '0}                 // sync error after a packet
   };

   // Register settings for the random phases, extremes included
   localparam int SETTING_COUNT = 8;
   localparam screen_setting_type SCREEN_SETTINGS [0:SETTING_COUNT-1] = '{
      '{13'd640,  13'd480,  8'd5,   3'd2},
      '{13'd4096, 13'd4096, 8'd0,   3'd4},
      '{13'd1,    13'd1,    8'd255, 3'd1},
      '{13'd8191, 13'd8191, 8'd128, 3'd7},
      '{13'd0,    13'd0,    8'd3,   3'd0},
      '{13'd320,  13'd200,  8'd10,  3'd3},
      '{13'd1000, 13'd700,  8'd20,  3'd5},
      '{13'd2,    13'd3000, 8'd1,   3'd6}
   };
   localparam int BYTES_PER_SETTING = 50;
   localparam int HOLD_OFF_CYCLES   = 60;

   logic                 clock;
   logic                 reset           = 1'b1;
   logic                 csr_we          = 1'b0;
   csr_index_type        csr_index       = CSR_SCREEN_WIDTH;
   logic [CFG_W-1:0]     csr_wdata       = '0;
   logic                 req_valid       = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_ctrl_status = '0;
   logic [7:0]           req_rx_byte     = '0;
   logic                 rsp_valid;
   logic                 rsp_ready       = 1'b0;
   logic [POS_W-1:0]     rsp_pos_x;
   logic [POS_W-1:0]     rsp_pos_y;
   logic [2:0]           rsp_button_bits;
   logic                 rsp_packet_done;
   logic                 rsp_motion_dropped;
   logic                 rsp_sync_error;
   logic [CNT_W-1:0]     rsp_packets_seen;
   logic [CNT_W-1:0]     rsp_errors_seen;

   ps2_mouse_packet_tracker_top dut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_ctrl_status    (req_ctrl_status),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pos_x          (rsp_pos_x),
      .rsp_pos_y          (rsp_pos_y),
      .rsp_button_bits    (rsp_button_bits),
      .rsp_packet_done    (rsp_packet_done),
      .rsp_motion_dropped (rsp_motion_dropped),
      .rsp_sync_error     (rsp_sync_error),
      .rsp_packets_seen   (rsp_packets_seen),
      .rsp_errors_seen    (rsp_errors_seen)
   );

   // Tracker state and register copies
   logic [CFG_W-1:0] cfg_width;
   logic [CFG_W-1:0] cfg_height;
   logic [7:0]       cfg_threshold;
   logic [2:0]       cfg_factor;
   phase_type        trk_phase;
   logic [7:0]       trk_header;
   logic [7:0]       trk_x_byte;
   logic [POS_W-1:0] trk_x;
   logic [POS_W-1:0] trk_y;
   logic [2:0]       trk_buttons;
   logic [CNT_W-1:0] trk_packets;
   logic [CNT_W-1:0] trk_errors;

   cursor_report_type expected_reports [$];
   int                failures         = 0;
   int                requests_taken   = 0;
   int                taken_bytes      = 0;
   int                burst_left       = 0;
   bit                sender_gaps_on   = 1'b0;
   bit                hold_off_pending = 1'b0;
   bit                pin_pending      = 1'b0;
   cursor_report_type pin_report;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Cursor tracker
   // ---------------------------------------------------------------------
   function automatic int scale_delta(input int d);
      int mag;
      mag = (d < 0) ? -d : d;
      if (mag > int'(cfg_threshold))
         return d * int'(cfg_factor);
      return d;
   endfunction

   // a zero size behaves as one; limit saturates at the position range
   function automatic logic [POS_W-1:0] clamp_to_screen(input int p,
                                                         input logic [CFG_W-1:0] size);
      int lim;
      lim = (size == '0) ? 0 : int'(size) - 1;
      if (lim > int'(MAX_POS))
         lim = int'(MAX_POS);
      if (p < 0)
         p = 0;
      if (p > lim)
         p = lim;
      return POS_W'(p);
   endfunction

   function automatic cursor_report_type track_byte(input logic [7:0] status,
                                                     input logic [7:0] data);
      cursor_report_type r;
      int                dx;
      int                dy;
      r = '0;
      if (status[STATUS_OUT_FULL] && status[STATUS_AUX_DATA]) begin
         case (trk_phase)
            PH_X_BYTE: begin
               trk_x_byte = data;
               trk_phase  = PH_Y_BYTE;
            end
            PH_Y_BYTE: begin
               dx = int'(trk_x_byte) - (trk_header[HDR_X_SIGN] ? 256 : 0);
               dy = int'(data) - (trk_header[HDR_Y_SIGN] ? 256 : 0);
               trk_phase     = PH_HEADER;
               r.packet_done = 1'b1;
               trk_packets   = trk_packets + 1'b1;
               trk_buttons   = trk_header[2:0];
               if (trk_header[HDR_X_OVFL] || trk_header[HDR_Y_OVFL]) begin
                  r.motion_dropped = 1'b1;
               end else begin
                  trk_x = clamp_to_screen(int'(trk_x) + scale_delta(dx), cfg_width);
                  trk_y = clamp_to_screen(int'(trk_y) - scale_delta(dy), cfg_height);
               end
            end
            default: begin
               if (!data[HDR_ALWAYS_ONE]) begin
                  trk_phase    = PH_HEADER;
                  r.sync_error = 1'b1;
                  trk_errors   = trk_errors + 1'b1;
               end else begin
                  trk_header = data;
                  trk_phase  = PH_X_BYTE;
               end
            end
         endcase
      end
      r.pos_x        = trk_x;
      r.pos_y        = trk_y;
      r.button_bits  = trk_buttons;
      r.packets_seen = trk_packets;
      r.errors_seen  = trk_errors;
      return r;
   endfunction

   task automatic compare_report(input cursor_report_type due, input cursor_report_type seen);
      if (seen.pos_x !== due.pos_x) begin
         $error("pos_x: expected %0d, got %0d", due.pos_x, seen.pos_x);
         failures++;
      end
      if (seen.pos_y !== due.pos_y) begin
         $error("pos_y: expected %0d, got %0d", due.pos_y, seen.pos_y);
         failures++;
      end
      if (seen.button_bits !== due.button_bits) begin
         $error("button_bits: expected %0d, got %0d", due.button_bits, seen.button_bits);
         failures++;
      end
      if (seen.packet_done !== due.packet_done) begin
         $error("packet_done: expected %0d, got %0d", due.packet_done, seen.packet_done);
         failures++;
      end
      if (seen.motion_dropped !== due.motion_dropped) begin
         $error("motion_dropped: expected %0d, got %0d",
                due.motion_dropped, seen.motion_dropped);
         failures++;
      end
      if (seen.sync_error !== due.sync_error) begin
         $error("sync_error: expected %0d, got %0d", due.sync_error, seen.sync_error);
         failures++;
      end
      if (seen.packets_seen !== due.packets_seen) begin
         $error("packets_seen: expected %0d, got %0d", due.packets_seen, seen.packets_seen);
         failures++;
      end
      if (seen.errors_seen !== due.errors_seen) begin
         $error("errors_seen: expected %0d, got %0d", due.errors_seen, seen.errors_seen);
         failures++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Handshake monitor: responses checked before the new request is queued
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cursor_report_type seen;
      cursor_report_type due;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_pos_x, rsp_pos_y, rsp_button_bits, rsp_packet_done,
                     rsp_motion_dropped, rsp_sync_error, rsp_packets_seen,
                     rsp_errors_seen};
            if (expected_reports.size() == 0) begin
               $error("response with no request outstanding");
               failures++;
            end else begin
               due = expected_reports.pop_front();
               compare_report(due, seen);
            end
         end
         if (req_valid && req_ready) begin
            due = track_byte(req_ctrl_status, req_rx_byte);
            if (pin_pending) begin
               due         = pin_report;
               pin_pending = 1'b0;
            end
            expected_reports.push_back(due);
            requests_taken++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response side: changes stall mode on its own, honours hold-off
   // ---------------------------------------------------------------------
   initial begin
      int hold_left;
      int mode;
      int mode_left;
      hold_left = 0;
      mode      = 0;
      mode_left = 0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         if (hold_off_pending && hold_left == 0) begin
            hold_left        = HOLD_OFF_CYCLES;
            hold_off_pending = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input logic [7:0] status, input logic [7:0] data);
      int count_before;
      count_before = requests_taken;
      req_valid       <= 1'b1;
      req_ctrl_status <= status;
      req_rx_byte     <= data;
      @(negedge clock);
      while (requests_taken == count_before)
         @(negedge clock);
   endtask

   // bursts of random length, with gaps between them when enabled
   task automatic offer_byte(input logic [7:0] status, input logic [7:0] data);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (sender_gaps_on) begin
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      if (status[STATUS_OUT_FULL] && status[STATUS_AUX_DATA])
         taken_bytes++;
      send_request(status, data);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CFG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_SCREEN_WIDTH:    cfg_width     = value;
         CSR_SCREEN_HEIGHT:   cfg_height    = value;
         CSR_ACCEL_THRESHOLD: cfg_threshold = value[7:0];
         CSR_ACCEL_FACTOR:    cfg_factor    = value[2:0];
      endcase
      @(negedge clock);
   endtask

   task automatic apply_setting(input screen_setting_type s);
      write_register(CSR_SCREEN_WIDTH, s.width);
      write_register(CSR_SCREEN_HEIGHT, s.height);
      write_register(CSR_ACCEL_THRESHOLD, CFG_W'(s.threshold));
      write_register(CSR_ACCEL_FACTOR, CFG_W'(s.factor));
      csr_we <= 1'b0;
   endtask

   function automatic logic [7:0] taken_status();
      logic [7:0] s;
      s = 8'($urandom);
      s[STATUS_OUT_FULL] = 1'b1;
      s[STATUS_AUX_DATA] = 1'b1;
      return s;
   endfunction

   function automatic logic [7:0] ignored_status();
      logic [7:0] s;
      s = 8'($urandom);
      if ($urandom_range(0, 1) == 0)
         s[STATUS_OUT_FULL] = 1'b0;
      else
         s[STATUS_AUX_DATA] = 1'b0;
      return s;
   endfunction

   // mostly small moves so the cursor spends time inside the screen
   function automatic logic [7:0] pick_delta(input logic negative);
      int mag;
      case ($urandom_range(0, 2))
         0:       mag = $urandom_range(0, 12);
         1:       mag = $urandom_range(0, 80);
         default: return 8'($urandom);
      endcase
      return negative ? 8'(-mag) : 8'(mag);
   endfunction

   // well-formed packets with random content, plus noise and broken ones
   task automatic run_random_bytes(input int target);
      logic [7:0] hdr;
      int         kind;
      taken_bytes = 0;
      while (taken_bytes < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            hdr = 8'($urandom);
            hdr[HDR_ALWAYS_ONE] = 1'b1;
            if ($urandom_range(0, 3) != 0) begin
               hdr[HDR_X_OVFL] = 1'b0;
               hdr[HDR_Y_OVFL] = 1'b0;
            end
            offer_byte(taken_status(), hdr);
            if ($urandom_range(0, 9) == 0)
               offer_byte(ignored_status(), 8'($urandom));
            offer_byte(taken_status(), pick_delta(hdr[HDR_X_SIGN]));
            offer_byte(taken_status(), pick_delta(hdr[HDR_Y_SIGN]));
         end else if (kind < 85) begin
            offer_byte(ignored_status(), 8'($urandom));
         end else if (kind < 93) begin
            hdr = 8'($urandom);
            hdr[HDR_ALWAYS_ONE] = 1'b0;
            offer_byte(taken_status(), hdr);
         end else begin
            // truncated packet: the next header lands in the wrong slot
            hdr = 8'($urandom);
            hdr[HDR_ALWAYS_ONE] = 1'b1;
            offer_byte(taken_status(), hdr);
            offer_byte(taken_status(), 8'($urandom));
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      cfg_width     = SCREEN_WIDTH_RESET;
      cfg_height    = SCREEN_HEIGHT_RESET;
      cfg_threshold = ACCEL_THRESHOLD_RESET;
      cfg_factor    = ACCEL_FACTOR_RESET;
      trk_phase     = PH_HEADER;
      trk_header    = '0;
      trk_x_byte    = '0;
      trk_x         = CURSOR_X_RESET;
      trk_y         = CURSOR_Y_RESET;
      trk_buttons   = '0;
      trk_packets   = '0;
      trk_errors    = '0;

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed requests under the reset settings
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         pin_pending = DIRECTED[i].typed;
         pin_report  = DIRECTED[i].want;
         send_request(DIRECTED[i].status, DIRECTED[i].data);
      end

      // random phases, one per register setting, written while idle
      for (int p = 0; p < SETTING_COUNT; p++) begin
         wait_drained();
         apply_setting(SCREEN_SETTINGS[p]);
         sender_gaps_on = (p % 3 != 0);
         burst_left     = 0;
         if (p == 1 || p == 5)
            hold_off_pending = 1'b1;
         run_random_bytes(BYTES_PER_SETTING);
      end

      wait_drained();
      repeat (4) @(negedge clock);
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
